// ===== hw/rtl/kslm_pkg.sv =====
// Shared types and constants for the k-way sorted list merge block.
// No dependencies; imported by every module of the block but kslm_ram.
package kslm_pkg;

    localparam int LISTS   = 8;
    localparam int DEPTH   = 256;

    localparam int LIST_W  = $clog2(LISTS);
    localparam int POS_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TOTAL_W = $clog2(LISTS * DEPTH + 1);
    localparam int ADDR_W  = $clog2(LISTS * DEPTH);
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_REFILL
    } state_t;

    // result of the head comparison tree
    typedef struct packed {
        logic                     found;
        logic [LIST_W-1:0]        idx;
        logic signed [DATA_W-1:0] value;
    } sel_t;

endpackage

// ===== hw/rtl/kslm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kslm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/kslm_min_select.sv =====
// Comparison tree over the cached list heads: smallest valid head, ties to lowest list.
// Depends on kslm_pkg.
module kslm_min_select
    import kslm_pkg::*;
(
    input  logic signed [DATA_W-1:0] heads [LISTS],
    input  logic [LISTS-1:0]         head_valid,
    output sel_t                     sel
);

    localparam int LEAVES = 2 ** LIST_W;
    localparam int NODES  = 2 * LEAVES - 1;

    sel_t node [NODES];

    // heap layout: node j has children 2j+1 (lower lists) and 2j+2
    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            node[LEAVES-1+i].idx = LIST_W'(i);
            if (i < LISTS)
            begin
                node[LEAVES-1+i].found = head_valid[i];
                node[LEAVES-1+i].value = heads[i];
            end
            else
            begin
                node[LEAVES-1+i].found = 1'b0;
                node[LEAVES-1+i].value = '0;
            end
        end
        for (int j = LEAVES - 2; j >= 0; j--)
        begin
            if (node[2*j+2].found
                && (!node[2*j+1].found || node[2*j+2].value < node[2*j+1].value))
            begin
                node[j] = node[2*j+2];
            end
            else
            begin
                node[j] = node[2*j+1];
            end
        end
    end

    assign sel = node[0];

endmodule

// ===== hw/rtl/kway_sorted_list_merge_top.sv =====
// Top level of the k-way sorted list merge: list FIFOs in one RAM, head cache, control.
// Depends on kslm_pkg, kslm_ram, kslm_min_select.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_ready  | action, list_id, value
//   out     | output    | out_valid / out_ready| merged_value, source_list, all_empty,
//           |           |                      | final_element
//
// A pop whose source list still holds further elements starts a RAM read of the new
// head and enters the refill state, in which the read data refills the head cache.
// A pop that empties its list, or finds all lists empty, needs no refill.
// Reset clears fill counts and read positions; the RAM needs no clearing.
// Input stalls while the result register holds an untaken transfer or a refill is busy.
module kway_sorted_list_merge_top
    import kslm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               action,
    input  logic [2:0]               list_id,
    input  logic signed [31:0]       value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [31:0]       merged_value,
    output logic [2:0]               source_list,
    output logic                     all_empty,
    output logic                     final_element
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         fill_reg  [LISTS];
    logic [CNT_W-1:0]         fill_next [LISTS];
    logic [POS_W-1:0]         rp_reg    [LISTS];
    logic [POS_W-1:0]         rp_next   [LISTS];
    logic [TOTAL_W-1:0]       total_reg, total_next;
    logic signed [DATA_W-1:0] head_reg  [LISTS];
    logic [LIST_W-1:0]        refill_list_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [2:0]               out_src_reg;
    logic                     out_empty_reg;
    logic                     out_final_reg;

    logic [LISTS-1:0]   head_valid;
    sel_t               sel;
    logic               in_xfer;
    logic               lid_ok;
    logic [LIST_W-1:0]  lid;
    logic [CNT_W:0]     tail_sum;
    logic [POS_W-1:0]   tail_pos;
    logic [POS_W-1:0]   next_pos;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;
    logic               out_load;
    logic               head_load;
    logic               refill_go;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [LIST_W-1:0] l,
                                                   input logic [POS_W-1:0]  p);
        mem_addr = ADDR_W'(ADDR_W'(l) * ADDR_W'(DEPTH)) + ADDR_W'(p);
    endfunction

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_xfer  = in_valid && in_ready;
    assign lid_ok   = 32'(list_id) < LISTS;
    assign lid      = LIST_W'(list_id);

    always_comb
    begin
        for (int i = 0; i < LISTS; i++)
        begin
            head_valid[i] = fill_reg[i] != '0;
        end
    end

    kslm_min_select u_min_select (
        .heads      (head_reg),
        .head_valid (head_valid),
        .sel        (sel)
    );

    // tail = (rp + fill) mod DEPTH; sum stays below twice DEPTH
    assign tail_sum = (CNT_W+1)'(rp_reg[lid]) + (CNT_W+1)'(fill_reg[lid]);
    assign tail_pos = (tail_sum >= (CNT_W+1)'(DEPTH)) ?
                      POS_W'(tail_sum - (CNT_W+1)'(DEPTH)) : POS_W'(tail_sum);
    assign next_pos = (32'(rp_reg[sel.idx]) == DEPTH - 1) ? '0 : rp_reg[sel.idx] + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (refill_go)
                begin
                    state_next = ST_REFILL;
                end
            end
            ST_REFILL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        fill_next  = fill_reg;
        rp_next    = rp_reg;
        total_next = total_reg;
        mem_we     = 1'b0;
        mem_waddr  = mem_addr(lid, tail_pos);
        mem_re     = 1'b0;
        mem_raddr  = mem_addr(sel.idx, next_pos);
        out_load   = 1'b0;
        head_load  = 1'b0;
        refill_go  = 1'b0;
        if (in_xfer)
        begin
            unique case (action)
                ACT_LOAD:
                begin
                    if (lid_ok && 32'(fill_reg[lid]) < DEPTH)
                    begin
                        mem_we         = 1'b1;
                        head_load      = fill_reg[lid] == '0;
                        fill_next[lid] = fill_reg[lid] + 1'b1;
                        total_next     = total_reg + 1'b1;
                    end
                end
                ACT_POP:
                begin
                    out_load = 1'b1;
                    if (sel.found)
                    begin
                        fill_next[sel.idx] = fill_reg[sel.idx] - 1'b1;
                        rp_next[sel.idx]   = next_pos;
                        total_next         = total_reg - 1'b1;
                        if (fill_reg[sel.idx] > CNT_W'(1))
                        begin
                            mem_re    = 1'b1;
                            refill_go = 1'b1;
                        end
                    end
                end
                ACT_CLEAR:
                begin
                    for (int i = 0; i < LISTS; i++)
                    begin
                        fill_next[i] = '0;
                        rp_next[i]   = '0;
                    end
                    total_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    kslm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LISTS * DEPTH)
    ) u_list_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LISTS; i++)
            begin
                fill_reg[i] <= '0;
                rp_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            fill_reg  <= fill_next;
            rp_reg    <= rp_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_load)
        begin
            head_reg[lid] <= value;
        end
        else if (state_reg == ST_REFILL)
        begin
            head_reg[refill_list_reg] <= mem_rdata;
        end
        if (refill_go)
        begin
            refill_list_reg <= sel.idx;
        end
        if (out_load)
        begin
            out_value_reg <= sel.found ? sel.value : '0;
            out_src_reg   <= sel.found ? 3'(sel.idx) : 3'd0;
            out_empty_reg <= !sel.found;
            out_final_reg <= sel.found && (total_reg == TOTAL_W'(1));
        end
    end

    assign out_valid     = out_valid_reg;
    assign merged_value  = out_value_reg;
    assign source_list   = out_src_reg;
    assign all_empty     = out_empty_reg;
    assign final_element = out_final_reg;

    // a refill always follows a pop whose result was just registered
    a_refill_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REFILL) |-> out_valid_reg)
        else $error("refill without pending result");

    a_refill_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REFILL) |=> (state_reg == ST_IDLE))
        else $error("refill lasted more than one cycle");

    // running total is nonzero exactly when some list holds an element
    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (sel.found == (total_reg != '0)))
        else $error("total count out of step with fill counts");

    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && action == ACT_POP) |=> out_valid_reg)
        else $error("pop transfer produced no result");

endmodule

// ===== sim/kway_sorted_list_merge_top_tb.sv =====
// Testbench for kway_sorted_list_merge_top: random load/pop/clear traffic with bursty input
// and a stalling receiver, each pop result checked against an in-bench merge predictor.
// Depends on kslm_pkg and the kway_sorted_list_merge_top RTL.
module kway_sorted_list_merge_top_tb
    import kslm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         ITEM_TARGET = 1300;
    localparam int         HOLD_CYCLES = 400;
    localparam int         TAIL_CYCLES = 20;

    typedef struct packed {
        logic signed [DATA_W-1:0] merged_value;
        logic [2:0]               source_list;
        logic                     all_empty;
        logic                     final_element;
    } merge_result_t;

    // Mirror of the list contents; predicts one result per pop.
    class merge_scoreboard_t;
        logic signed [DATA_W-1:0] lists [LISTS][DEPTH];
        int unsigned              fill [LISTS];
        int unsigned              head [LISTS];
        merge_result_t            pops_due [$];
        int                       errors;
        int                       reported;

        function new();
            errors   = 0;
            reported = 0;
            empty_lists();
        endfunction

        function void empty_lists();
            for (int i = 0; i < LISTS; i++)
            begin
                fill[i] = 0;
                head[i] = 0;
            end
        endfunction

        function int pending();
            return pops_due.size();
        endfunction

        function void note_input(logic [1:0] act, logic [2:0] lid,
                                 logic signed [DATA_W-1:0] val);
            merge_result_t r;
            int            best;
            int unsigned   total;
            if (act == ACT_LOAD)
            begin
                if (fill[lid] < DEPTH)
                begin
                    lists[lid][(head[lid] + fill[lid]) % DEPTH] = val;
                    fill[lid]++;
                end
            end
            else if (act == ACT_CLEAR)
            begin
                empty_lists();
            end
            else if (act == ACT_POP)
            begin
                best  = -1;
                total = 0;
                for (int i = 0; i < LISTS; i++)
                begin
                    if (fill[i] != 0)
                    begin
                        total += fill[i];
                        // strict less-than keeps ties on the lowest list
                        if (best < 0 || lists[i][head[i]] < lists[best][head[best]])
                            best = i;
                    end
                end
                if (best < 0)
                begin
                    r.merged_value  = '0;
                    r.source_list   = '0;
                    r.all_empty     = 1'b1;
                    r.final_element = 1'b0;
                end
                else
                begin
                    r.merged_value  = lists[best][head[best]];
                    r.source_list   = 3'(best);
                    r.all_empty     = 1'b0;
                    r.final_element = (total == 1);
                    fill[best]--;
                    head[best] = (head[best] + 1) % DEPTH;
                end
                pops_due = {pops_due, r};
            end
        endfunction

        function void check_result(merge_result_t got);
            merge_result_t want;
            if (pops_due.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected result: value %0d list %0d empty %0b final %0b",
                             got.merged_value, got.source_list, got.all_empty,
                             got.final_element);
                end
                return;
            end
            want = pops_due.pop_front();
            if (got.merged_value !== want.merged_value || got.source_list !== want.source_list
                || got.all_empty !== want.all_empty
                || got.final_element !== want.final_element)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("mismatch: exp value %0d list %0d empty %0b final %0b",
                             want.merged_value, want.source_list, want.all_empty,
                             want.final_element);
                    $display("          got value %0d list %0d empty %0b final %0b",
                             got.merged_value, got.source_list, got.all_empty,
                             got.final_element);
                end
            end
        endfunction

        function void flag_leftover();
            if (pops_due.size() != 0)
            begin
                errors += pops_due.size();
                $display("%0d pop results never arrived", pops_due.size());
            end
        endfunction
    endclass

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_ready;
    logic [1:0]               action        = ACT_LOAD;
    logic [2:0]               list_id       = '0;
    logic signed [31:0]       value         = '0;
    logic                     out_valid;
    logic                     out_ready     = 1'b0;
    logic signed [31:0]       merged_value;
    logic [2:0]               source_list;
    logic                     all_empty;
    logic                     final_element;

    merge_scoreboard_t sb;
    int              items_sent  = 0;
    int              burst_left  = 0;
    int              hold_asked  = 0;
    int              hold_done   = 0;
    bit              hold_used   = 1'b0;
    bit              fill_done   = 1'b0;

    kway_sorted_list_merge_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .list_id       (list_id),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .merged_value  (merged_value),
        .source_list   (source_list),
        .all_empty     (all_empty),
        .final_element (final_element)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // transfer monitor: inputs update the predictor, results get checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(action, list_id, value);
            if (out_valid && out_ready)
                sb.check_result('{merged_value, source_list, all_empty, final_element});
        end
    end

    // receiver: changing stall patterns, plus long hold-offs on request
    initial
    begin : receiver
        int mode;
        int span;
        int phase;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span)
            begin
                @(posedge clk);
                phase++;
                if (hold_asked != hold_done)
                begin
                    hold_done = hold_done + 1;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                else
                begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= (phase % 4 != 3);
                    endcase
                end
            end
        end
    end

    task automatic offer(input logic [1:0] act, input logic [2:0] lid,
                         input logic signed [31:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        action   <= act;
        list_id  <= lid;
        value    <= val;
        do @(posedge clk); while (!in_ready);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic wait_drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic pop_any();
        offer(ACT_POP, 3'($urandom), $urandom);
    endtask

    // sorted loads spread over random lists with occasional pops, then enough pops to empty them or a clear halfway
    task automatic merge_round();
        int  vals [LISTS][$];
        int  total;
        int  left;
        int  n;
        int  lid;
        int  pops;
        bit  narrow;
        total  = 0;
        narrow = ($urandom_range(0, 2) == 0);
        for (int k = 0; k < LISTS; k++)
        begin
            vals[k].delete();
            if ($urandom_range(0, 1) == 1)
            begin
                n = $urandom_range(1, 10);
                repeat (n)
                    vals[k] = {vals[k], narrow ? int'($urandom_range(0, 12)) - 6
                                               : int'($urandom)};
                vals[k].sort();
                total += n;
            end
        end
        left = total;
        while (left > 0)
        begin
            do lid = $urandom_range(0, LISTS - 1); while (vals[lid].size() == 0);
            offer(ACT_LOAD, 3'(lid), vals[lid].pop_front());
            left--;
            if ($urandom_range(0, 7) == 0)
                pop_any();
        end
        if (!hold_used && items_sent >= 150)
        begin
            hold_used  = 1'b1;
            hold_asked <= hold_asked + 1;
        end
        pops = total + $urandom_range(0, 2);
        if ($urandom_range(0, 5) == 0)
        begin
            // abandon the merge halfway
            repeat (pops / 2) pop_any();
            offer(ACT_CLEAR, 3'($urandom), $urandom);
        end
        else
        begin
            repeat (pops) pop_any();
        end
    endtask

    task automatic noise_round();
        repeat ($urandom_range(3, 10))
            offer(2'($urandom_range(0, 3)), 3'($urandom), $urandom);
    endtask

    // one list filled to capacity, overfilled, then its circular store wrapped
    task automatic fill_round();
        logic [2:0] lid;
        int         base;
        lid  = 3'($urandom_range(0, LISTS - 1));
        base = int'($urandom_range(0, 4000)) - 2000;
        offer(ACT_CLEAR, 3'($urandom), $urandom);
        for (int i = 0; i < DEPTH; i++)
            offer(ACT_LOAD, lid, base + 2 * i);
        repeat (2) offer(ACT_LOAD, lid, base + 3 * DEPTH);
        offer(ACT_LOAD, lid + 3'd1, base + 7);
        repeat (40) pop_any();
        for (int i = 0; i < 30; i++)
            offer(ACT_LOAD, lid, base + 2 * DEPTH + i);
        repeat (12) pop_any();
        offer(ACT_CLEAR, lid, $urandom);
    endtask

    initial
    begin : stimulus
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(ACT_POP, 3'd5, 32'h1234_5678);           // nothing held yet
        offer(ACT_LOAD, 3'd0, 32'h8000_0000);
        offer(ACT_LOAD, 3'd7, 32'h7fff_ffff);
        offer(ACT_LOAD, 3'd3, 32'sd0);
        offer(ACT_LOAD, 3'd3, 32'sd0);
        offer(ACT_LOAD, 3'd5, 32'sd0);                  // ties with list 3
        offer(ACT_LOAD, 3'd1, 32'hffff_ffff);
        offer(ACT_UNUSED, 3'd2, 32'h5555_aaaa);
        offer(ACT_UNUSED, 3'd5, 32'haaaa_5555);
        repeat (8) offer(ACT_POP, 3'd7, 32'hffff_ffff); // drains, then two empty pops
        offer(ACT_LOAD, 3'd2, -32'sd5);
        offer(ACT_LOAD, 3'd6, 32'sd9);
        offer(ACT_CLEAR, 3'd6, 32'h7fff_ffff);
        offer(ACT_POP, 3'd0, 32'sd0);
        offer(ACT_LOAD, 3'd4, 32'sd42);
        offer(ACT_POP, 3'd4, 32'sd42);
        wait_drain();

        while (items_sent < ITEM_TARGET)
        begin
            if (!fill_done && items_sent >= 400)
            begin
                fill_done = 1'b1;
                fill_round();
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                merge_round();
            end
            else
            begin
                noise_round();
            end
            if ($urandom_range(0, 7) == 0)
                wait_drain();
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.flag_leftover();
        if (sb.errors == 0)
            $display("kway_sorted_list_merge_top_tb: done, clean");
        else
            $display("kway_sorted_list_merge_top_tb: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("kway_sorted_list_merge_top_tb: done, errors");
        $finish;
    end

endmodule
